@@ design/mqtt_publish_payload_extractor_macros.svh @@
// Assertion macros used by the publish payload extractor top level.
`ifndef MQTT_PUBLISH_PAYLOAD_EXTRACTOR_MACROS_SVH
`define MQTT_PUBLISH_PAYLOAD_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MPPE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define MPPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MPPE_ASSERT_NOW(label, clk, rst, ante, cons)
`define MPPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/mppe_pkg.sv @@
// Types and constants of the publish payload extractor.
`default_nettype none
package mppe_pkg;

   // Default cap on the number of payload bytes taken from one packet.
   localparam int unsigned MPPE_MAX_PAYLOAD = 128;

   // Byte codes that the parser looks for.
   localparam logic [7:0] SEPARATOR_CHAR = 8'h3A;
   localparam logic [7:0] TYPE_MASK      = 8'hF0;
   localparam logic [7:0] TYPE_PUBLISH   = 8'h30;

   // Parser phases, one-hot.
   typedef enum logic [9:0] {
      PH_SEEK       = 10'b00_0000_0001,
      PH_TYPE       = 10'b00_0000_0010,
      PH_REMLEN     = 10'b00_0000_0100,
      PH_TOPIC_HI   = 10'b00_0000_1000,
      PH_TOPIC_LO   = 10'b00_0001_0000,
      PH_TOPIC_SKIP = 10'b00_0010_0000,
      PH_PROPLEN    = 10'b00_0100_0000,
      PH_PROP_SKIP  = 10'b00_1000_0000,
      PH_PAYLOAD    = 10'b01_0000_0000,
      PH_DRAIN      = 10'b10_0000_0000
   } phase_type;

   // Parser state carried from word to word.
   typedef struct packed {
      phase_type   phase;
      logic [7:0]  remaining_length;
      logic [15:0] topic_length;
      logic [7:0]  properties_length;
      logic [15:0] skip_count;
      logic [7:0]  payload_left;
      logic [7:0]  emitted_count;
   } parse_state_type;

   // One result word, with a flag that says whether the input word made one.
   typedef struct packed {
      logic       valid;
      logic [7:0] payload_byte;
      logic       data_valid;
      logic       message_end;
      logic [7:0] message_length;
   } result_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      phase:             PH_SEEK,
      remaining_length:  8'd0,
      topic_length:      16'd0,
      properties_length: 8'd0,
      skip_count:        16'd0,
      payload_left:      8'd0,
      emitted_count:     8'd0
   };

endpackage
`default_nettype wire

@@ design/mppe_step.sv @@
// Next-state and result logic of the parser for one received word.
`default_nettype none
module mppe_step
   import mppe_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MPPE_MAX_PAYLOAD
) (
   input  parse_state_type cur_state,
   input  logic [7:0]      rx_byte,
   input  logic            buffer_end,
   output parse_state_type nxt_state,
   output result_type      result
);

   logic [7:0]  prop_len;
   logic [15:0] raw_len;
   logic [15:0] capped_len;
   logic [7:0]  hdr_left;
   logic        hdr_done;
   logic [15:0] skip_dec;
   logic [7:0]  left_dec;
   logic [7:0]  emit_inc;
   logic        pay_end;

   // Payload count from the header fields, wrapped to 16 bits and capped.
   assign prop_len   = (cur_state.phase == PH_PROPLEN) ? rx_byte : cur_state.properties_length;
   assign raw_len    = {8'd0, cur_state.remaining_length} - 16'd3
                       - cur_state.topic_length - {8'd0, prop_len};
   assign capped_len = (raw_len > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD) : raw_len;
   assign hdr_left   = capped_len[7:0];

   assign skip_dec = cur_state.skip_count - 16'd1;
   assign left_dec = cur_state.payload_left - 8'd1;
   assign emit_inc = cur_state.emitted_count + 8'd1;
   assign pay_end  = (left_dec == 8'd0) || buffer_end;

   // Phase sequencing and result generation.
   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      hdr_done  = 1'b0;
      case (cur_state.phase)
         PH_TYPE: begin
            nxt_state.phase = ((rx_byte & TYPE_MASK) == TYPE_PUBLISH) ? PH_REMLEN : PH_DRAIN;
         end
         PH_REMLEN: begin
            nxt_state.remaining_length = rx_byte;
            nxt_state.phase            = PH_TOPIC_HI;
         end
         PH_TOPIC_HI: begin
            nxt_state.topic_length = {rx_byte, 8'd0};
            nxt_state.phase        = PH_TOPIC_LO;
         end
         PH_TOPIC_LO: begin
            nxt_state.topic_length = cur_state.topic_length | {8'd0, rx_byte};
            nxt_state.skip_count   = cur_state.topic_length | {8'd0, rx_byte};
            nxt_state.phase = ((cur_state.topic_length | {8'd0, rx_byte}) == 16'd0)
                              ? PH_PROPLEN : PH_TOPIC_SKIP;
         end
         PH_TOPIC_SKIP: begin
            nxt_state.skip_count = skip_dec;
            if (skip_dec == 16'd0) begin
               nxt_state.phase = PH_PROPLEN;
            end
         end
         PH_PROPLEN: begin
            nxt_state.properties_length = rx_byte;
            nxt_state.skip_count        = {8'd0, rx_byte};
            if (rx_byte == 8'd0) begin
               hdr_done = 1'b1;
            end else begin
               nxt_state.phase = PH_PROP_SKIP;
            end
         end
         PH_PROP_SKIP: begin
            nxt_state.skip_count = skip_dec;
            if (skip_dec == 16'd0) begin
               hdr_done = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            nxt_state.emitted_count = emit_inc;
            nxt_state.payload_left  = left_dec;
            result.valid            = 1'b1;
            result.payload_byte     = rx_byte;
            result.data_valid       = 1'b1;
            result.message_end      = pay_end;
            result.message_length   = emit_inc;
            if (pay_end) begin
               nxt_state.phase = PH_DRAIN;
            end
         end
         PH_DRAIN: begin
            nxt_state.phase = PH_DRAIN;
         end
         default: begin
            nxt_state.phase = (rx_byte == SEPARATOR_CHAR) ? PH_TYPE : PH_SEEK;
         end
      endcase

      // The header is complete: an empty payload or a buffer end closes the message.
      if (hdr_done) begin
         nxt_state.emitted_count = 8'd0;
         nxt_state.payload_left  = hdr_left;
         if ((hdr_left == 8'd0) || buffer_end) begin
            result.valid       = 1'b1;
            result.message_end = 1'b1;
            nxt_state.phase    = PH_DRAIN;
         end else begin
            nxt_state.phase = PH_PAYLOAD;
         end
      end

      // The last word of a buffer always restarts the search.
      if (buffer_end) begin
         nxt_state.phase = PH_SEEK;
      end
   end

endmodule
`default_nettype wire

@@ design/mqtt_publish_payload_extractor.sv @@
// Top level of the publish payload extractor: input register, parser, result register.
// Words pass the input register and the parser; any result waits in the output register.
// Throughput: one word per cycle without stalls; only the parser lies between stages.
// A result waiting in the output register holds the input word and the parser state.
// Reset (synchronous, active high) empties both stages and returns the parser to the
// separator search with all counters and lengths cleared.
`default_nettype none
`include "mqtt_publish_payload_extractor_macros.svh"
module mqtt_publish_payload_extractor
   import mppe_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MPPE_MAX_PAYLOAD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_buffer_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_data_valid,
   output logic       rsp_message_end,
   output logic [7:0] rsp_message_length
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      step_result;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic [7:0]      out_byte_ff;
   logic            out_data_valid_ff;
   logic            out_end_ff;
   logic [7:0]      out_length_ff;
   logic            advance;
   logic            req_take;

   // The input word moves on when the output register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   mppe_step #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_step (
      .cur_state  (state_ff),
      .rx_byte    (in_byte_ff),
      .buffer_end (in_last_ff),
      .nxt_state  (state_in),
      .result     (step_result)
   );

   // Input register.
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
         in_last_ff <= req_buffer_end;
      end
   end

   // Parser state advances with each word that leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   assign out_valid_in = advance ? step_result.valid : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && step_result.valid) begin
         out_byte_ff       <= step_result.payload_byte;
         out_data_valid_ff <= step_result.data_valid;
         out_end_ff        <= step_result.message_end;
         out_length_ff     <= step_result.message_length;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_data_valid     = out_data_valid_ff;
   assign rsp_message_end    = out_end_ff;
   assign rsp_message_length = out_length_ff;

   // A word held behind a stalled result must block the input side.
   `MPPE_ASSERT_NOW(a_stall_blocks_input, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_ready, !req_ready)
   // A result without data is an empty message end.
   `MPPE_ASSERT_NOW(a_empty_end, clock, reset,
      rsp_valid && !rsp_data_valid, rsp_message_end && (rsp_message_length == 8'd0))
   // A data result counts at least one byte and never passes the cap.
   `MPPE_ASSERT_NOW(a_length_bound, clock, reset,
      rsp_valid && rsp_data_valid,
      (rsp_message_length != 8'd0) && (rsp_message_length <= 8'(MAX_PAYLOAD)))
   // Every word leaving the parser on a buffer end sends it back to the search.
   `MPPE_ASSERT_NEXT(a_buffer_end_restart, clock, reset,
      advance && in_last_ff, state_ff.phase == PH_SEEK)

endmodule
`default_nettype wire
